// File: hdl/edd_pkg.sv
// Shared types and constants for the Elias delta decoder.
// No dependencies.
package edd_pkg;

    localparam int WORD_W      = 32;
    localparam int BUF_W       = 73;
    localparam int CNT_W       = 7;
    localparam int ZERO_RUN    = 6;
    localparam int MAX_LEFT    = 41;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_beat;

endpackage

// File: hdl/edd_front.sv
// Input side: accepts word beats into a short queue ahead of the decoder.
// Depends on edd_pkg.
module edd_front #(
    parameter int DEPTH = edd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  edd_pkg::t_beat i_beat,
    output logic          o_valid,
    input  logic          i_ready,
    output edd_pkg::t_beat o_beat
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    edd_pkg::t_beat r_mem [DEPTH];
    logic [IDX_W-1:0]  r_wr, r_rd;
    logic [FILL_W-1:0] r_fill;
    logic              push, pop;

    assign o_ready = (r_fill != FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_beat  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// File: hdl/edd_back.sv
// Decode engine: bit buffer, one code step per cycle if not stalled,
// hold stage for end-of-run mark, output register. Depends on edd_pkg.
module edd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  edd_pkg::t_beat             i_beat,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [edd_pkg::WORD_W-1:0] o_value,
    output logic                       o_last
);

    localparam int BW = edd_pkg::BUF_W;
    localparam int CW = edd_pkg::CNT_W;
    localparam int WW = edd_pkg::WORD_W;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_DECODE = 1'b1;

    localparam logic [1:0] A_DROP_RUN  = 2'd0;
    localparam logic [1:0] A_BREAK     = 2'd1;
    localparam logic [1:0] A_DROP_HEAD = 2'd2;
    localparam logic [1:0] A_EMIT      = 2'd3;

    logic          r_state;
    logic [BW-1:0] r_buf;
    logic [CW-1:0] r_count;
    logic          r_end;
    logic          r_hold_v;
    logic [WW-1:0] r_hold_val;
    logic          r_o_valid;
    logic [WW-1:0] r_o_value;
    logic          r_o_last;

    logic [2:0]    z;
    logic [11:0]   kwin;
    logic [5:0]    k;
    logic [3:0]    head;
    logic [5:0]    total;
    logic [BW-1:0] shifted;
    logic [WW-1:0] val;
    logic [1:0]    act;
    logic [5:0]    drop_n;
    logic          out_free;
    logic          step_ok;
    logic          to_out;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_value  = r_o_value;
    assign o_last   = r_o_last;
    assign out_free = !r_o_valid || i_ready;

    always_comb begin
        z = 3'd6;
        for (int j = 5; j >= 0; j--) begin
            if (r_buf[BW-1-j]) begin
                z = 3'(j);
            end
        end
        kwin    = r_buf[BW-1 -: 12] << z;
        k       = 6'(kwin[11:6] >> (3'd5 - z));
        head    = {z, 1'b1};
        total   = 6'(head) + k - 6'd1;
        shifted = r_buf << head;
        val     = {1'b1, shifted[BW-1 -: WW-1]} >> 5'(6'd32 - k);

        if (z == 3'(edd_pkg::ZERO_RUN) && r_count >= CW'(edd_pkg::ZERO_RUN)) begin
            act    = A_DROP_RUN;
            drop_n = 6'(edd_pkg::ZERO_RUN);
        end else if (CW'(z) >= r_count || r_count < CW'(head)) begin
            act    = A_BREAK;
            drop_n = '0;
        end else if (k > 6'(WW)) begin
            act    = A_DROP_HEAD;
            drop_n = 6'(head);
        end else if (r_count < CW'(total)) begin
            act    = A_BREAK;
            drop_n = '0;
        end else begin
            act    = A_EMIT;
            drop_n = total;
        end

        step_ok = !r_hold_v || out_free || act == A_DROP_RUN || act == A_DROP_HEAD;
        to_out  = (r_state == S_DECODE) && step_ok && r_hold_v
                  && (act == A_EMIT || act == A_BREAK);
    end

    always_ff @(posedge i_clk) begin
        if (to_out) begin
            r_o_value <= r_hold_val;
            r_o_last  <= (act == A_BREAK);
        end
        if (r_state == S_DECODE && act == A_EMIT && step_ok) begin
            r_hold_val <= val;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_end <= i_beat.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_buf     <= '0;
            r_count   <= '0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (to_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_buf   <= r_buf | ({i_beat.word, (BW-WW)'(0)} >> r_count);
                        r_count <= r_count + CW'(WW);
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (step_ok) begin
                        if (act == A_BREAK) begin
                            r_hold_v <= 1'b0;
                            r_state  <= S_IDLE;
                            if (r_end) begin
                                r_buf   <= '0;
                                r_count <= '0;
                            end
                        end else begin
                            r_buf   <= r_buf << drop_n;
                            r_count <= r_count - CW'(drop_n);
                            if (act == A_EMIT) begin
                                r_hold_v <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held value left over at end of word");

    a_idle_leftover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count <= CW'(edd_pkg::MAX_LEFT)))
        else $error("leftover bits exceed an incomplete code");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_value != '0))
        else $error("decoded value is zero");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BW))
        else $error("bit count beyond buffer");

endmodule

// File: hdl/elias_delta_decoder.sv
// Top level of the Elias delta decoder: input queue feeding the decode engine.
// Depends on edd_pkg, edd_front, edd_back.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_code_word, i_stream_end
//  out      source     o_out_valid / i_out_ready  o_value, o_last_of_run
//
// The decode engine loads a word, then takes code steps (values plus dropped
// prefixes) until a break; it resolves one code a cycle unless stalled.
// Reset (synchronous, i_rst_n low) empties the queue and the bit buffer.
// A stalled output holds the engine only when a value must move on; the
// queue keeps taking words meanwhile until it is full.
module elias_delta_decoder #(
    parameter int QUEUE_DEPTH = edd_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [edd_pkg::WORD_W-1:0] i_code_word,
    input  logic                       i_stream_end,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [edd_pkg::WORD_W-1:0] o_value,
    output logic                       o_last_of_run
);

    edd_pkg::t_beat in_beat, q_beat;
    logic           q_valid, q_ready;

    assign in_beat.word = i_code_word;
    assign in_beat.last = i_stream_end;

    edd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (in_beat),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_beat  (q_beat)
    );

    edd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_beat  (q_beat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_value (o_value),
        .o_last  (o_last_of_run)
    );

endmodule

// File: tb/sv/elias_delta_decoder_test.sv
// Testbench for elias_delta_decoder: random Elias delta streams and noise words, with
// a bit-level predictor of the decoded values checked beat by beat on the output.
// Depends on edd_pkg and the elias_delta_decoder RTL.
`timescale 1ns / 100ps

module elias_delta_decoder_test;

    localparam int WORD_W = edd_pkg::WORD_W;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              hold;
    } t_word_item;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } t_decoded;

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_BURSTY} t_ready_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [WORD_W-1:0] i_code_word;
    logic              i_stream_end;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [WORD_W-1:0] o_value;
    logic              o_last_of_run;

    elias_delta_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_code_word   (i_code_word),
        .i_stream_end  (i_stream_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor state: stream bit i sits at stream_buf[127 - i].
    logic [127:0] stream_buf;
    int unsigned  stream_cnt;

    t_word_item  word_q[$];
    t_decoded    decoded_q[$];
    bit          code_bits[$];

    t_word_item  cur;
    t_decoded    want;
    logic        in_beat;
    int          fail_cnt;
    int          cycle_cnt;
    int          burst_left;
    int          gap_left;
    int          ready_left;
    t_ready_mode ready_mode;

    function automatic logic buf_bit_at(int unsigned i);
        return stream_buf[127 - (i & 127)];
    endfunction

    function automatic logic [31:0] buf_take(int unsigned off, int unsigned n);
        logic [31:0] v;
        int unsigned i;
        v = '0;
        for (i = 0; i < n && i < 32; i++)
            v = {v[30:0], buf_bit_at(off + i)};
        return v;
    endfunction

    task automatic buf_shift(int unsigned n);
        stream_buf = (n >= 128) ? '0 : (stream_buf << n);
        stream_cnt = (n >= stream_cnt) ? 0 : stream_cnt - n;
    endtask

    task automatic decode_word(logic [WORD_W-1:0] word, logic last);
        int unsigned z, p, k, head, total, i;
        int          n;
        logic [63:0] val;
        t_decoded    d;
        n = 0;
        if (stream_cnt > 96)
            stream_cnt = 96;
        for (i = 0; i < 32; i++)
            if (word[31-i])
                stream_buf[127 - ((stream_cnt + i) & 127)] = 1'b1;
        stream_cnt += 32;
        while (n < 32) begin
            z = 0;
            while (z < 6 && z < stream_cnt && buf_bit_at(z) == 1'b0)
                z++;
            if (z == 6) begin
                buf_shift(6);
                continue;
            end
            if (z >= stream_cnt)
                break;
            p = z + 1;
            head = 2 * p - 1;
            if (stream_cnt < head)
                break;
            k = buf_take(z, p);
            if (k > 32) begin
                buf_shift(head);
                continue;
            end
            total = head + k - 1;
            if (stream_cnt < total)
                break;
            val = (64'd1 << (k - 1)) | {32'd0, buf_take(head, k - 1)};
            d.value = val[31:0];
            d.last = 1'b0;
            decoded_q.push_back(d);
            n++;
            buf_shift(total);
        end
        if (n > 0) begin
            d = decoded_q.pop_back();
            d.last = 1'b1;
            decoded_q.push_back(d);
        end
        if (last) begin
            stream_buf = '0;
            stream_cnt = 0;
        end
    endtask

    // Stream construction.
    function automatic int unsigned bit_len(logic [31:0] v);
        int unsigned n, i;
        n = 0;
        for (i = 0; i < 32; i++)
            if (v[i])
                n = i + 1;
        return n;
    endfunction

    task automatic add_value(logic [31:0] v);
        int unsigned k, p, i;
        logic [31:0] kv;
        k = bit_len(v);
        kv = k;
        p = bit_len(kv);
        for (i = 1; i < p; i++)
            code_bits.push_back(1'b0);
        for (i = p; i > 0; i--)
            code_bits.push_back(kv[i-1]);
        for (i = k - 1; i > 0; i--)
            code_bits.push_back(v[i-1]);
    endtask

    task automatic add_bad_len(int unsigned kbad);
        logic [5:0] kv;
        int         i;
        kv = 6'(kbad);
        for (i = 0; i < 5; i++)
            code_bits.push_back(1'b0);
        for (i = 5; i >= 0; i--)
            code_bits.push_back(kv[i]);
    endtask

    task automatic add_zeros(int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            code_bits.push_back(1'b0);
    endtask

    function automatic logic [31:0] rand_value();
        int unsigned len;
        logic [31:0] v;
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 32);
        v = $urandom;
        v = v >> (32 - len);
        v[len-1] = 1'b1;
        return v;
    endfunction

    task automatic push_word(logic [31:0] word, logic last, logic hold);
        t_word_item it;
        it.word = word;
        it.last = last;
        it.hold = hold;
        word_q.push_back(it);
    endtask

    // Chop the pending code bits into words, zero padded; end flag on the last one.
    task automatic pack_stream(logic end_flag, logic hold);
        logic [31:0] w;
        logic        first;
        int unsigned i;
        first = 1'b1;
        while (code_bits.size() != 0) begin
            w = '0;
            for (i = 0; i < 32; i++)
                if (code_bits.size() != 0)
                    w[31-i] = code_bits.pop_front();
            push_word(w, end_flag && code_bits.size() == 0, hold && first);
            first = 1'b0;
        end
    endtask

    initial begin : stimulus
        int n0, rand_items, ncodes, j, sel;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_code_word = '0;
        i_stream_end = 1'b0;
        i_out_ready = 1'b0;
        stream_buf = '0;
        stream_cnt = 0;
        fail_cnt = 0;
        burst_left = 1;
        gap_left = 0;
        ready_left = 0;
        ready_mode = READY_ALWAYS;

        // Directed: all ones (32 results), long zero runs, flush.
        push_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_word(32'h0000_0000, 1'b0, 1'b1);
        push_word(32'h0000_0000, 1'b1, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1, 1'b0);
        // Extreme values, oversized lengths, zero run ahead of a code.
        add_value(32'd1);
        add_value(32'hFFFF_FFFF);
        add_value(32'h8000_0000);
        add_value(32'd2);
        add_value(32'd3);
        add_value(32'h7FFF_FFFF);
        add_bad_len(33);
        add_bad_len(63);
        add_zeros(7);
        add_value(32'd5);
        add_value(32'hFFFF_FFFF);
        pack_stream(1'b1, 1'b0);
        // Incomplete code dropped at stream end.
        add_value(32'hFFFF_FFFF);
        for (j = 0; j < 22; j++)
            void'(code_bits.pop_back());
        pack_stream(1'b1, 1'b0);
        // 41 bits left pending across a word boundary.
        for (j = 0; j < 23; j++)
            add_value(32'd1);
        add_value(32'hFFFF_FFFF);
        for (j = 0; j < 31; j++)
            add_value(32'd1);
        pack_stream(1'b1, 1'b0);

        rand_items = 0;
        while (rand_items < 120) begin
            n0 = word_q.size();
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                ncodes = $urandom_range(1, 16);
                for (j = 0; j < ncodes; j++) begin
                    case ($urandom_range(0, 19))
                        0:       add_bad_len($urandom_range(33, 63));
                        1:       add_zeros($urandom_range(6, 12));
                        default: add_value(rand_value());
                    endcase
                end
                pack_stream($urandom_range(0, 3) == 0,
                            rand_items == 0 || $urandom_range(0, 19) == 0);
            end else if (sel == 7) begin
                ncodes = $urandom_range(1, 3);
                for (j = 0; j < ncodes; j++)
                    push_word($urandom, 1'($urandom_range(0, 1)), 1'b0);
            end else begin
                add_value(rand_value());
                ncodes = $urandom_range(1, code_bits.size());
                for (j = 0; j < ncodes; j++)
                    void'(code_bits.pop_back());
                if (code_bits.size() == 0)
                    add_zeros(1);
                pack_stream(1'b1, 1'b0);
            end
            rand_items += word_q.size() - n0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Sender: bursts of beats separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beat)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (word_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                cur = word_q[0];
                if (cur.hold && decoded_q.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    word_q.delete(0);
                    i_in_valid <= 1'b1;
                    i_code_word <= cur.word;
                    i_stream_end <= cur.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern switches to a random mode after a random stretch.
    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 80);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: i_out_ready <= (ready_left % 4 == 0);
            default:      i_out_ready <= ((ready_left % 16) < 4);
        endcase
    end

    // Monitor: predict on each accepted word, check each output beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_beat <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                decode_word(i_code_word, i_stream_end);
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("value: expected none, got %h", o_value);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, o_value);
                        fail_cnt++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, o_last_of_run);
                        fail_cnt++;
                    end
                end
            end
        end else begin
            in_beat <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial cycle_cnt = 0;

endmodule
